// ----- sv/pia_pkg.sv -----
// Shared types, codes and constants for the positional insert/remove array.
`timescale 1ns / 1ps

package pia_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int ELEM_WIDTH_DEF = 32;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 4;
  localparam int VALUE_W  = 32;
  localparam int FCNT_W   = 5;
  localparam int RVAL_W   = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_GET    = 3'd3,
    CMD_SET    = 3'd4,
    CMD_FILL   = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic exec;
  } ctl_t;

endpackage

// ----- sv/pia_ctrl.sv -----
// Handshake controller: tracks the output register and issues execute strobes.
`timescale 1ns / 1ps

module pia_ctrl
  import pia_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  output ctl_t ctl
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_HOLD = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   exec;

  assign in_tready  = (state_r == S_IDLE) || out_tready;
  assign exec       = in_tvalid && in_tready;
  assign out_tvalid = (state_r == S_HOLD);
  assign ctl.exec   = exec;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (exec) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (out_tready && !exec) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/pia_dpath.sv -----
// Datapath: element cells, fill count and result register.
`timescale 1ns / 1ps

module pia_dpath
  import pia_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ctl_t                ctl,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [POS_W-1:0]    pos,
  input  logic [VALUE_W-1:0]  value,
  input  logic [FCNT_W-1:0]   fill_count,
  output logic [RVAL_W-1:0]   read_value,
  output logic [COUNT_W-1:0]  count,
  output logic                is_empty,
  output logic [STATUS_W-1:0] status
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > FCNT_W) ? CW : FCNT_W;
  localparam logic [CMPW-1:0] CAP_X = CMPW'(CAPACITY);

  logic [ELEM_WIDTH-1:0] elem_r   [CAPACITY];
  logic [ELEM_WIDTH-1:0] elem_nxt [CAPACITY];
  logic [ELEM_WIDTH-1:0] up       [CAPACITY];
  logic [ELEM_WIDTH-1:0] dn       [CAPACITY];
  logic [CW-1:0]         count_r, count_nxt;

  logic [RVAL_W-1:0]   rval_r, rval_nxt;
  logic [COUNT_W-1:0]  cnt_out_r;
  logic                empty_r;
  status_t             status_r, status_nxt;

  logic [CMPW-1:0]       pos_x, count_x, fcnt_x;
  logic [IW-1:0]         idx;
  logic [ELEM_WIDTH-1:0] val_w;
  logic                  pos_ok;

  assign pos_x   = CMPW'(pos);
  assign count_x = CMPW'(count_r);
  assign fcnt_x  = CMPW'(fill_count);
  assign idx     = pos_x[IW-1:0];
  assign val_w   = ELEM_WIDTH'(value);
  assign pos_ok  = (pos_x < count_x) && (pos_x < CAP_X);

  // neighbor taps for the shift-up and shift-down moves
  always_comb begin
    up[0]          = elem_r[0];
    dn[CAPACITY-1] = elem_r[CAPACITY-1];
    for (int i = 1; i < CAPACITY; i++) begin
      up[i]   = elem_r[i-1];
      dn[i-1] = elem_r[i];
    end
  end

  always_comb begin
    elem_nxt   = elem_r;
    count_nxt  = count_r;
    rval_nxt   = '0;
    status_nxt = ST_OK;
    unique case (cmd)
      CMD_APPEND: begin
        if (count_x >= CAP_X) begin
          status_nxt = ST_FULL;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (CMPW'(i) == count_x) elem_nxt[i] = val_w;
          end
          count_nxt = CW'(count_r + 1'b1);
        end
      end
      CMD_INSERT: begin
        if (!pos_ok) begin
          status_nxt = ST_BADPOS;
        end else if (count_x >= CAP_X) begin
          status_nxt = ST_FULL;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (CMPW'(i) == pos_x) begin
              elem_nxt[i] = val_w;
            end else if (CMPW'(i) > pos_x && CMPW'(i) <= count_x) begin
              elem_nxt[i] = up[i];
            end
          end
          count_nxt = CW'(count_r + 1'b1);
        end
      end
      CMD_REMOVE: begin
        if (!pos_ok) begin
          status_nxt = ST_BADPOS;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (CMPW'(i) >= pos_x && CMPW'(i + 1) < count_x) elem_nxt[i] = dn[i];
          end
          count_nxt = CW'(count_r - 1'b1);
        end
      end
      CMD_GET: begin
        if (!pos_ok) begin
          status_nxt = ST_BADPOS;
        end else begin
          rval_nxt = RVAL_W'(elem_r[idx]);
        end
      end
      CMD_SET: begin
        if (!pos_ok) begin
          status_nxt = ST_BADPOS;
        end else begin
          elem_nxt[idx] = val_w;
        end
      end
      CMD_FILL: begin
        if (fcnt_x > CAP_X) begin
          status_nxt = ST_FULL;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (CMPW'(i) < fcnt_x) elem_nxt[i] = '0;
          end
          count_nxt = CW'(fcnt_x);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      elem_r    <= elem_nxt;
      rval_r    <= rval_nxt;
      cnt_out_r <= COUNT_W'(count_nxt);
      empty_r   <= (count_nxt == '0);
      status_r  <= status_nxt;
    end
  end

  assign read_value = rval_r;
  assign count      = cnt_out_r;
  assign is_empty   = empty_r;
  assign status     = status_r;

endmodule

// ----- sv/positional_insert_remove_array.sv -----
// Top level of the positional insert/remove array.
`timescale 1ns / 1ps

// Ordered array of CAPACITY words with a fill count, driven by command beats.
// Input channel in_*: in_tuser carries the command (append, insert, remove,
// get, set, fill with zeros); in_tdata carries pos, value and fill_count.
// Output channel out_*: one result beat per command with the read value,
// the count after the command, an empty flag and a status code
// (ok, full / fill too large, position not below count).
// Each command executes in the cycle it is accepted: all cells shift in
// parallel, so the result appears in the cycle after the input beat; a new
// beat is taken every cycle while out_tready is high, one command per cycle.
// The result sits in an output register; while it waits, the next command
// is still accepted if out_tready is high in that cycle. When the receiver
// stalls, the result holds and in_tready drops until it is taken.
// Reset empties the array (count zero) and clears the output valid; element
// contents are not cleared and are only read below the count.
// A command that cannot be carried out changes nothing and reports why.
module positional_insert_remove_array
  import pia_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // pos[3:0], value[35:4], fill_count[40:36]
  input  logic [CMD_W-1:0]       in_tuser,   // cmd[2:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // read_value[31:0], count[36:32],
                                             // is_empty[37], status[39:38]
);

  ctl_t                ctl;
  logic [RVAL_W-1:0]   read_value;
  logic [COUNT_W-1:0]  count;
  logic                is_empty;
  logic [STATUS_W-1:0] status;

  pia_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl)
  );

  pia_dpath #(
    .CAPACITY   (CAPACITY),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .cmd        (in_tuser),
    .pos        (in_tdata[3:0]),
    .value      (in_tdata[35:4]),
    .fill_count (in_tdata[40:36]),
    .read_value (read_value),
    .count      (count),
    .is_empty   (is_empty),
    .status     (status)
  );

  assign out_tdata = {status, is_empty, count, read_value};

endmodule

// ----- tb/sv/positional_insert_remove_array_test.sv -----
// Scoreboarded stream testbench for the positional insert/remove array.
`timescale 1ns / 1ps

module positional_insert_remove_array_test;
  import pia_pkg::*;

  localparam int          CAP          = CAPACITY_DEF;
  localparam int          LIMIT_CYCLES = 200000;
  localparam logic [2:0]  CMD_RSVD6    = 3'd6;
  localparam logic [2:0]  CMD_RSVD7    = 3'd7;

  typedef struct packed {
    status_t               status;
    logic                  is_empty;
    logic [COUNT_W-1:0]    count;
    logic [RVAL_W-1:0]     read_value;
  } array_result_t;

  class pia_scoreboard;
    logic [VALUE_W-1:0] cells[CAP];
    int                 level;
    array_result_t      pending[$];
    int                 errors;
    int                 n_cmd[8];
    int                 n_status[4];
    int                 n_results;

    function new();
      foreach (cells[i]) cells[i] = '0;
      level     = 0;
      errors    = 0;
      n_results = 0;
      foreach (n_cmd[i]) n_cmd[i] = 0;
      foreach (n_status[i]) n_status[i] = 0;
    endfunction

    // apply one accepted command to the shadow array and queue its result
    function void note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                               logic [VALUE_W-1:0] value, logic [FCNT_W-1:0] fcnt);
      array_result_t res;
      bit            pos_ok;
      int            i;
      res.read_value = '0;
      res.status     = ST_OK;
      pos_ok         = int'(pos) < level;
      n_cmd[cmd]++;
      case (cmd)
        CMD_APPEND: begin
          if (level >= CAP) res.status = ST_FULL;
          else begin
            cells[level] = value;
            level++;
          end
        end
        CMD_INSERT: begin
          if (!pos_ok) res.status = ST_BADPOS;
          else if (level >= CAP) res.status = ST_FULL;
          else begin
            for (i = level; i > int'(pos); i--) cells[i] = cells[i-1];
            cells[pos] = value;
            level++;
          end
        end
        CMD_REMOVE: begin
          if (!pos_ok) res.status = ST_BADPOS;
          else begin
            for (i = int'(pos); i + 1 < level; i++) cells[i] = cells[i+1];
            level--;
          end
        end
        CMD_GET: begin
          if (!pos_ok) res.status = ST_BADPOS;
          else res.read_value = cells[pos];
        end
        CMD_SET: begin
          if (!pos_ok) res.status = ST_BADPOS;
          else cells[pos] = value;
        end
        CMD_FILL: begin
          if (int'(fcnt) > CAP) res.status = ST_FULL;
          else begin
            for (i = 0; i < int'(fcnt); i++) cells[i] = '0;
            level = int'(fcnt);
          end
        end
        default: ;
      endcase
      res.count    = COUNT_W'(level);
      res.is_empty = (level == 0);
      pending.push_back(res);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] beat);
      array_result_t got;
      array_result_t exp;
      got = array_result_t'(beat);
      if (pending.size() == 0) begin
        $error("result beat with no command waiting: %h", beat);
        errors++;
        return;
      end
      exp = pending.pop_front();
      n_results++;
      n_status[exp.status]++;
      if (got.read_value !== exp.read_value) begin
        $error("read_value: expected %h, got %h", exp.read_value, got.read_value);
        errors++;
      end
      if (got.count !== exp.count) begin
        $error("count: expected %0d, got %0d", exp.count, got.count);
        errors++;
      end
      if (got.is_empty !== exp.is_empty) begin
        $error("is_empty: expected %b, got %b", exp.is_empty, got.is_empty);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]       in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] out_tdata;

  pia_scoreboard sb = new();
  int            gap_pct = 0;
  int            stall_pct = 0;
  int            stall_left = 0;
  int            cycles = 0;

  positional_insert_remove_array i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("positional_insert_remove_array_test: done, errors");
      $finish;
    end
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (stall_pct == 0) begin
      stall_left <= 0;
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(1, 6) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                          input logic [VALUE_W-1:0] value, input logic [FCNT_W-1:0] fcnt);
    int gap;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'b0, fcnt, value, pos};
    do @(posedge clk); while (!in_tready);
    sb.note_command(cmd, pos, value, fcnt);
  endtask

  // hold the sender until every queued result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic random_run(input int n, input bit grow);
    logic [CMD_W-1:0]   cmd;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
    logic [FCNT_W-1:0]  fcnt;
    int                 r;
    int                 lvl;
    for (int k = 0; k < n; k++) begin
      lvl = sb.level;
      r = $urandom_range(0, 99);
      if (r < (grow ? 35 : 15))      cmd = CMD_APPEND;
      else if (r < (grow ? 55 : 30)) cmd = CMD_INSERT;
      else if (r < (grow ? 65 : 60)) cmd = CMD_REMOVE;
      else if (r < 78)               cmd = CMD_GET;
      else if (r < 91)               cmd = CMD_SET;
      else if (r < 96)               cmd = CMD_FILL;
      else if (r < 98)               cmd = CMD_RSVD6;
      else                           cmd = CMD_RSVD7;
      if (lvl > 0 && $urandom_range(0, 9) != 0) pos = POS_W'($urandom_range(0, lvl - 1));
      else pos = POS_W'($urandom_range(0, 15));
      r = $urandom_range(0, 9);
      if (r < 7)       fcnt = FCNT_W'($urandom_range(0, CAP));
      else if (r < 8)  fcnt = FCNT_W'(CAP);
      else             fcnt = FCNT_W'($urandom_range(CAP + 1, 31));
      r = $urandom_range(0, 19);
      if (r == 0)      value = '0;
      else if (r == 1) value = '1;
      else             value = $urandom;
      send_cmd(cmd, pos, value, fcnt);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    gap_pct   = 20;
    stall_pct = 20;

    // empty array rejects each positional command, then full and fill cases
    send_cmd(CMD_GET,    4'd0,  32'h1234_5678, 5'd0);
    send_cmd(CMD_REMOVE, 4'd0,  32'h0,         5'd0);
    send_cmd(CMD_INSERT, 4'd0,  32'hDEAD_BEEF, 5'd0);
    send_cmd(CMD_SET,    4'd15, 32'hFFFF_FFFF, 5'd0);
    send_cmd(CMD_APPEND, 4'd15, 32'hFFFF_FFFF, 5'd0);
    send_cmd(CMD_APPEND, 4'd0,  32'h0000_0000, 5'd0);
    send_cmd(CMD_INSERT, 4'd0,  32'hAAAA_AAAA, 5'd0);
    send_cmd(CMD_INSERT, 4'd3,  32'h1111_1111, 5'd0);
    send_cmd(CMD_GET,    4'd0,  32'h0,         5'd0);
    send_cmd(CMD_GET,    4'd1,  32'h0,         5'd0);
    send_cmd(CMD_SET,    4'd1,  32'h5555_5555, 5'd0);
    send_cmd(CMD_GET,    4'd1,  32'h0,         5'd0);
    send_cmd(CMD_REMOVE, 4'd0,  32'h0,         5'd0);
    send_cmd(CMD_GET,    4'd1,  32'h0,         5'd0);
    send_cmd(CMD_FILL,   4'd0,  32'h0,         5'd16);
    send_cmd(CMD_APPEND, 4'd0,  32'h7777_7777, 5'd0);
    send_cmd(CMD_INSERT, 4'd15, 32'h8888_8888, 5'd0);
    send_cmd(CMD_SET,    4'd15, 32'hCAFE_F00D, 5'd0);
    send_cmd(CMD_GET,    4'd15, 32'h0,         5'd0);
    send_cmd(CMD_REMOVE, 4'd15, 32'h0,         5'd0);
    send_cmd(CMD_FILL,   4'd0,  32'h0,         5'd17);
    send_cmd(CMD_FILL,   4'd0,  32'h0,         5'd31);
    send_cmd(CMD_RSVD6,  4'd15, 32'hFFFF_FFFF, 5'd31);
    send_cmd(CMD_RSVD7,  4'd0,  32'h0,         5'd0);
    send_cmd(CMD_FILL,   4'd0,  32'h0,         5'd0);
    send_cmd(CMD_FILL,   4'd0,  32'h0,         5'd1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 15; stall_pct = 15; end
        default: begin gap_pct = 40; stall_pct = 40; end
      endcase
      random_run(60, ph % 2 == 0);
      drain();
    end

    // closing stretch at full rate
    gap_pct   = 0;
    stall_pct = 0;
    random_run(40, 1'b1);
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d results never arrived", sb.pending.size());
      sb.errors++;
    end

    $display("commands: append %0d insert %0d remove %0d get %0d set %0d fill %0d unused %0d",
             sb.n_cmd[CMD_APPEND], sb.n_cmd[CMD_INSERT], sb.n_cmd[CMD_REMOVE],
             sb.n_cmd[CMD_GET], sb.n_cmd[CMD_SET], sb.n_cmd[CMD_FILL],
             sb.n_cmd[CMD_RSVD6] + sb.n_cmd[CMD_RSVD7]);
    $display("results checked %0d: ok %0d, full %0d, bad position %0d, mismatches %0d",
             sb.n_results, sb.n_status[ST_OK], sb.n_status[ST_FULL],
             sb.n_status[ST_BADPOS], sb.errors);
    if (sb.errors == 0) begin
      $display("positional_insert_remove_array_test: done, clean");
    end else begin
      $display("positional_insert_remove_array_test: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/pia_pkg.sv
sv/pia_ctrl.sv
sv/pia_dpath.sv
sv/positional_insert_remove_array.sv
tb/sv/positional_insert_remove_array_test.sv
